@@ rtl/tslope_pkg.sv @@
// ----------------------------------------------------------------------------
// tslope_pkg
// Shared types and constants of the 3x3 terrain slope block.
// ----------------------------------------------------------------------------
package tslope_pkg;

  localparam int MAX_WIDTH_DEF   = 4096;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 24;
  localparam int FW_W       = 13;
  localparam int FH_W       = 16;
  localparam int NODATA_W   = 16;
  localparam int GAIN_W     = 24;
  localparam int SLOPE_W    = 8;

  localparam int SCALED_W = 24;            // scaled difference below 256.0 in Q16
  localparam int SQ_W     = 2 * SCALED_W;
  localparam int X_W      = SQ_W + 4;      // 4 * (ew^2 + ns^2), even width
  localparam int ROOT_W   = X_W / 2;
  localparam int REM_W    = ROOT_W + 3;
  localparam int ITER_W   = $clog2(ROOT_W);
  localparam int RND_BIT  = 16;
  localparam int RND_SH   = 17;

  localparam logic [FW_W-1:0]       FW_RESET     = 13'd4096;
  localparam logic [FH_W-1:0]       FH_RESET     = 16'd4096;
  localparam logic [NODATA_W-1:0]   NODATA_RESET = 16'h8000;
  localparam logic [GAIN_W-1:0]     GAIN_RESET   = 24'd2088960;
  localparam logic [SLOPE_W-1:0]    SLOPE_MAX    = 8'd255;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_NODATA       = 3'd2,
    REG_EW_GAIN      = 3'd3,
    REG_NS_GAIN      = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    F_IDLE,
    F_UPD
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_SQ,
    B_ADD,
    B_ROOT,
    B_RND,
    B_OUT
  } back_state_t;

  typedef struct packed {
    logic compute;
    logic eof;
  } res_ctl_t;

endpackage

@@ rtl/tslope_queue.sv @@
// ----------------------------------------------------------------------------
// tslope_queue
// Two-entry queue between the window front end and the slope back end.
// ----------------------------------------------------------------------------
module tslope_queue #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output logic [DATA_W-1:0] pop_data
);

  logic [DATA_W-1:0] slot_r [2];
  logic              wptr_r, wptr_nxt;
  logic              rptr_r, rptr_nxt;
  logic [1:0]        cnt_r, cnt_nxt;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign pop_data  = slot_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = ~wptr_r;
    end
    if (pop) begin
      rptr_nxt = ~rptr_r;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_data;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push || pop) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty) else $error("queue underflow");
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> cnt_r == $past(cnt_r) + 2'd1) else $error("queue count slip");
`endif

endmodule

@@ rtl/tslope_front.sv @@
// ----------------------------------------------------------------------------
// tslope_front
// Sample intake: row stores, 3x3 window, raster counters, result classification.
// ----------------------------------------------------------------------------
module tslope_front #(
  parameter int MAX_WIDTH   = tslope_pkg::MAX_WIDTH_DEF,
  parameter int SAMPLE_BITS = tslope_pkg::SAMPLE_BITS_DEF,
  parameter int IN_W        = ((SAMPLE_BITS + 7) / 8) * 8,
  parameter int MAG_W       = SAMPLE_BITS + 3
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [IN_W-1:0]                   in_tdata,
  input  logic [0:0]                        in_tuser,
  input  logic [tslope_pkg::FW_W-1:0]       frame_width,
  input  logic [tslope_pkg::FH_W-1:0]       frame_height,
  input  logic [tslope_pkg::NODATA_W-1:0]   nodata_value,
  input  logic                              geom_clr,
  input  logic                              q_full,
  output logic                              q_push,
  output tslope_pkg::res_ctl_t              q_ctl,
  output logic [MAG_W-1:0]                  q_mag_ew,
  output logic [MAG_W-1:0]                  q_mag_ns
);

  import tslope_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int CMP = 33;

  front_state_t state_r, state_nxt;

  logic [SAMPLE_BITS-1:0] mem_up  [MAX_WIDTH];
  logic [SAMPLE_BITS-1:0] mem_mid [MAX_WIDTH];

  logic [SAMPLE_BITS-1:0] win_r [9];
  logic [SAMPLE_BITS-1:0] kn    [9];
  logic [SAMPLE_BITS-1:0] rd_up_r, rd_mid_r, sample_r;
  logic                   flush_r, done_r;

  logic [CW-1:0]   col_r, col_nxt;
  logic [FH_W-1:0] row_r, row_nxt;
  logic [CW-1:0]   ocol_r, ocol_nxt;
  logic [FH_W-1:0] orow_r, orow_nxt;

  logic [CW-1:0]   wm1;
  logic [FH_W-1:0] hm1;
  logic [FH_W-1:0] h_eff;
  logic            accept, done_input, has_result, interior, eof, nodata_hit;
  logic            upd;

  logic signed [MAG_W-1:0] ew, ns;
  logic signed [CMP-1:0]   nd_ext;

  always_comb begin
    if (frame_width < FW_W'(3)) begin
      wm1 = CW'(2);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      wm1 = CW'(MAX_WIDTH - 1);
    end else begin
      wm1 = CW'(frame_width - FW_W'(1));
    end
    h_eff = (frame_height < FH_W'(3)) ? FH_W'(3) : frame_height;
    hm1   = h_eff - FH_W'(1);
  end

  assign done_input = (row_r >= h_eff);
  assign accept     = in_tvalid && in_tready;
  assign upd        = (state_r == F_UPD) && !flush_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          state_nxt = F_UPD;
        end
      end
      F_UPD: begin
        state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_tready = 1'b0;
    q_push    = 1'b0;
    unique case (state_r)
      F_IDLE: in_tready = !q_full;
      F_UPD:  q_push    = has_result;
      default: ;
    endcase
  end

  always_comb begin
    kn[0] = win_r[1];
    kn[1] = win_r[2];
    kn[2] = rd_up_r;
    kn[3] = win_r[4];
    kn[4] = win_r[5];
    kn[5] = rd_mid_r;
    kn[6] = win_r[7];
    kn[7] = win_r[8];
    kn[8] = sample_r;
  end

  always_comb begin
    nd_ext     = CMP'($signed(nodata_value));
    nodata_hit = 1'b0;
    for (int i = 0; i < 9; i++) begin
      if (CMP'($signed(kn[i])) == nd_ext) begin
        nodata_hit = 1'b1;
      end
    end
    ew = (MAG_W'($signed(kn[0])) + (MAG_W'($signed(kn[3])) <<< 1) + MAG_W'($signed(kn[6])))
       - (MAG_W'($signed(kn[2])) + (MAG_W'($signed(kn[5])) <<< 1) + MAG_W'($signed(kn[8])));
    ns = (MAG_W'($signed(kn[0])) + (MAG_W'($signed(kn[1])) <<< 1) + MAG_W'($signed(kn[2])))
       - (MAG_W'($signed(kn[6])) + (MAG_W'($signed(kn[7])) <<< 1) + MAG_W'($signed(kn[8])));
    q_mag_ew = ew[MAG_W-1] ? MAG_W'(-ew) : MAG_W'(ew);
    q_mag_ns = ns[MAG_W-1] ? MAG_W'(-ns) : MAG_W'(ns);
  end

  always_comb begin
    interior   = (orow_r != '0) && (orow_r != hm1) && (ocol_r != '0) && (ocol_r != wm1);
    eof        = (orow_r == hm1) && (ocol_r == wm1);
    has_result = flush_r ? done_r
                         : !((row_r == '0) || ((row_r == FH_W'(1)) && (col_r == '0)));
    q_ctl.compute = !flush_r && interior && !nodata_hit;
    q_ctl.eof     = eof;
  end

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    ocol_nxt = ocol_r;
    orow_nxt = orow_r;
    if (upd) begin
      if (col_r == wm1) begin
        col_nxt = '0;
        row_nxt = row_r + FH_W'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
    if (q_push) begin
      if (ocol_r == wm1) begin
        ocol_nxt = '0;
        orow_nxt = orow_r + FH_W'(1);
      end else begin
        ocol_nxt = ocol_r + CW'(1);
      end
    end
    if ((q_push && eof) || geom_clr) begin
      col_nxt  = '0;
      row_nxt  = '0;
      ocol_nxt = '0;
      orow_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      col_r   <= '0;
      row_r   <= '0;
      ocol_r  <= '0;
      orow_r  <= '0;
      flush_r <= 1'b0;
      done_r  <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      ocol_r  <= ocol_nxt;
      orow_r  <= orow_nxt;
      if (accept) begin
        flush_r <= in_tuser[0] || done_input;
        done_r  <= done_input;
      end
      if (upd) begin
        for (int i = 0; i < 9; i++) begin
          win_r[i] <= kn[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_r <= in_tdata[SAMPLE_BITS-1:0];
      rd_up_r  <= mem_up[col_r];
      rd_mid_r <= mem_mid[col_r];
    end
    if (upd) begin
      mem_up[col_r]  <= rd_mid_r;
      mem_mid[col_r] <= sample_r;
    end
  end

`ifndef SYNTH
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= wm1 && ocol_r <= wm1) else $error("column past row end");
  a_push_upd: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> state_r == F_UPD) else $error("push outside update");
  a_accept_room: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !(q_full && q_push)) else $error("push without room");
`endif

endmodule

@@ rtl/tslope_back.sv @@
// ----------------------------------------------------------------------------
// tslope_back
// Gain scaling, square sum, bit-serial square root, rounding and output stage.
// ----------------------------------------------------------------------------
module tslope_back #(
  parameter int MAG_W = tslope_pkg::SAMPLE_BITS_DEF + 3
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [tslope_pkg::GAIN_W-1:0]   ew_gain,
  input  logic [tslope_pkg::GAIN_W-1:0]   ns_gain,
  input  logic                            q_not_empty,
  input  tslope_pkg::res_ctl_t            q_ctl,
  input  logic [MAG_W-1:0]                q_mag_ew,
  input  logic [MAG_W-1:0]                q_mag_ns,
  output logic                            q_pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [tslope_pkg::SLOPE_W-1:0]  out_tdata,
  output logic                            out_tlast
);

  import tslope_pkg::*;

  localparam int PROD_W = MAG_W + GAIN_W;

  back_state_t state_r, state_nxt;

  logic [MAG_W-1:0]    mag_ew_r, mag_ns_r;
  logic [PROD_W-1:0]   se_r, sn_r;
  logic [SQ_W-1:0]     sqe_r, sqn_r;
  logic [X_W-1:0]      x_r;
  logic [REM_W-1:0]    rem_r;
  logic [ROOT_W-1:0]   root_r;
  logic [ITER_W-1:0]   iter_r;
  logic [SLOPE_W-1:0]  slope_r;
  logic                eof_r;

  logic                sat;
  logic [REM_W-1:0]    rem_sh, trial;
  logic                ge;
  logic [ROOT_W:0]     rnd_sum;
  logic [ROOT_W-RND_SH:0] n_val;

  assign sat     = (se_r[PROD_W-1:SCALED_W] != '0) || (sn_r[PROD_W-1:SCALED_W] != '0);
  assign rem_sh  = {rem_r[REM_W-3:0], x_r[X_W-1 -: 2]};
  assign trial   = REM_W'({root_r, 2'b01});
  assign ge      = (rem_sh >= trial);
  assign rnd_sum = {1'b0, root_r} + (ROOT_W+1)'(1 << RND_BIT);
  assign n_val   = rnd_sum[ROOT_W:RND_SH];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (q_not_empty) begin
          state_nxt = q_ctl.compute ? B_MUL : B_OUT;
        end
      end
      B_MUL:  state_nxt = B_SQ;
      B_SQ:   state_nxt = sat ? B_OUT : B_ADD;
      B_ADD:  state_nxt = B_ROOT;
      B_ROOT: begin
        if (iter_r == ITER_W'(ROOT_W - 1)) begin
          state_nxt = B_RND;
        end
      end
      B_RND:  state_nxt = B_OUT;
      B_OUT: begin
        if (out_tready) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop      = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      B_IDLE:  q_pop      = q_not_empty;
      B_OUT:   out_tvalid = 1'b1;
      default: ;
    endcase
  end

  assign out_tdata = slope_r;
  assign out_tlast = eof_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        mag_ew_r <= q_mag_ew;
        mag_ns_r <= q_mag_ns;
        eof_r    <= q_ctl.eof;
        slope_r  <= '0;
      end
      B_MUL: begin
        se_r <= PROD_W'(mag_ew_r) * PROD_W'(ew_gain);
        sn_r <= PROD_W'(mag_ns_r) * PROD_W'(ns_gain);
      end
      B_SQ: begin
        sqe_r   <= SQ_W'(se_r[SCALED_W-1:0]) * SQ_W'(se_r[SCALED_W-1:0]);
        sqn_r   <= SQ_W'(sn_r[SCALED_W-1:0]) * SQ_W'(sn_r[SCALED_W-1:0]);
        slope_r <= SLOPE_MAX;
      end
      B_ADD: begin
        x_r    <= X_W'({1'b0, sqe_r} + {1'b0, sqn_r}) << 2;
        rem_r  <= '0;
        root_r <= '0;
        iter_r <= '0;
      end
      B_ROOT: begin
        rem_r  <= ge ? rem_sh - trial : rem_sh;
        root_r <= {root_r[ROOT_W-2:0], ge};
        x_r    <= x_r << 2;
        iter_r <= iter_r + ITER_W'(1);
      end
      B_RND: begin
        slope_r <= (n_val > (ROOT_W-RND_SH+1)'(SLOPE_MAX)) ? SLOPE_MAX : SLOPE_W'(n_val);
      end
      default: ;
    endcase
  end

`ifndef SYNTH
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == B_IDLE) else $error("pop while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(slope_r)) else $error("result lost");
  a_root_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_RND |-> iter_r == ITER_W'(ROOT_W)) else $error("root iteration count");
`endif

endmodule

@@ rtl/terrain_slope_3x3_top.sv @@
// ----------------------------------------------------------------------------
// terrain_slope_3x3_top
// Streaming 3x3 Horn slope magnitude over a raster of signed elevations.
// ----------------------------------------------------------------------------
// In the front end each input transfer is handled as a row store read, then a
// window and store update. A result that needs the slope passes through gain
// multiply, squaring, sum, the one-bit-per-cycle square root and rounding in the
// back end; border and no-data results go straight to output. A two-entry queue
// between the two lets intake run ahead of the arithmetic. Results lag the samples
// by width+1 pixels; send transfers with tuser set after the frame to drain the tail.
module terrain_slope_3x3_top #(
  parameter int MAX_WIDTH   = tslope_pkg::MAX_WIDTH_DEF,
  parameter int SAMPLE_BITS = tslope_pkg::SAMPLE_BITS_DEF,
  parameter int IN_W        = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [IN_W-1:0]                     in_tdata,   // elevation
  input  logic [0:0]                          in_tuser,   // flush
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [tslope_pkg::SLOPE_W-1:0]      out_tdata,  // slope_value
  output logic                                out_tlast,
  input  logic                                cfg_we,
  input  logic [tslope_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [tslope_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  import tslope_pkg::*;

  localparam int MAG_W = SAMPLE_BITS + 3;
  localparam int QW    = $bits(res_ctl_t) + 2 * MAG_W;

  logic [FW_W-1:0]     fw_r;
  logic [FH_W-1:0]     fh_r;
  logic [NODATA_W-1:0] nodata_r;
  logic [GAIN_W-1:0]   ew_gain_r, ns_gain_r;
  logic                geom_clr;

  logic             q_full, q_push, q_pop, q_not_empty;
  res_ctl_t         f_ctl, b_ctl;
  logic [MAG_W-1:0] f_ew, f_ns, b_ew, b_ns;
  logic [QW-1:0]    q_out;

  always_comb begin
    geom_clr = 1'b0;
    if (cfg_we) begin
      unique case (cfg_addr)
        REG_FRAME_WIDTH, REG_FRAME_HEIGHT: geom_clr = 1'b1;
        default: geom_clr = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r      <= FW_RESET;
      fh_r      <= FH_RESET;
      nodata_r  <= NODATA_RESET;
      ew_gain_r <= GAIN_RESET;
      ns_gain_r <= GAIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_FRAME_WIDTH:  fw_r      <= cfg_wdata[FW_W-1:0];
        REG_FRAME_HEIGHT: fh_r      <= cfg_wdata[FH_W-1:0];
        REG_NODATA:       nodata_r  <= cfg_wdata[NODATA_W-1:0];
        REG_EW_GAIN:      ew_gain_r <= cfg_wdata[GAIN_W-1:0];
        REG_NS_GAIN:      ns_gain_r <= cfg_wdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  tslope_front #(
    .MAX_WIDTH   (MAX_WIDTH),
    .SAMPLE_BITS (SAMPLE_BITS),
    .IN_W        (IN_W),
    .MAG_W       (MAG_W)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .frame_width  (fw_r),
    .frame_height (fh_r),
    .nodata_value (nodata_r),
    .geom_clr     (geom_clr),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_ctl        (f_ctl),
    .q_mag_ew     (f_ew),
    .q_mag_ns     (f_ns)
  );

  tslope_queue #(
    .DATA_W (QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({f_ctl, f_ew, f_ns}),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_out)
  );

  assign b_ctl = q_out[QW-1 -: $bits(res_ctl_t)];
  assign b_ew  = q_out[2*MAG_W-1 -: MAG_W];
  assign b_ns  = q_out[MAG_W-1:0];

  tslope_back #(
    .MAG_W (MAG_W)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .ew_gain     (ew_gain_r),
    .ns_gain     (ns_gain_r),
    .q_not_empty (q_not_empty),
    .q_ctl       (b_ctl),
    .q_mag_ew    (b_ew),
    .q_mag_ns    (b_ns),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

`ifndef SYNTH
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full || q_pop) else $error("queue push blocked");
  a_tlast_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> !q_pop) else $error("pop during frame end");
  a_geom_clr: assert property (@(posedge clk) disable iff (!rst_n)
    geom_clr |-> cfg_we) else $error("clear without write");
`endif

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for terrain_slope_3x3_top. Rasters of signed elevations
// go in under random bursts and gaps while the result side stalls on its own
// pattern. A local slope model predicts each result (slope byte and frame end)
// and the checker compares every result with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import tslope_pkg::*;

  localparam int MAXW        = 4096;
  localparam int IDLE_WAIT   = 80;
  localparam int STALL_LIMIT = 4000;
  localparam int ITEM_GOAL   = 1300;

  typedef struct packed {
    logic [SLOPE_W-1:0] slope;
    logic               eof;
  } slope_res_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [15:0]           in_tdata = '0;
  logic [0:0]            in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [SLOPE_W-1:0]    out_tdata;
  logic                  out_tlast;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  terrain_slope_3x3_top u_top (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast,
    .cfg_we, .cfg_addr, .cfg_wdata
  );

  always #6 clk = ~clk;

  // slope model state
  int          upper_row [MAXW];
  int          middle_row [MAXW];
  int          win [9];
  int unsigned col_cnt, row_cnt, out_cnt;
  int unsigned fw_reg, fh_reg;
  int          nodata_reg;
  longint unsigned ew_gain, ns_gain;

  slope_res_t  pending_slopes [$];
  int          errors = 0;
  int          items_sent = 0;
  int          results_seen = 0;
  int          frames_done = 0;
  int          burst_left = 0;
  int          idle_cycles = 0;

  function automatic longint unsigned floor_root(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic int unsigned cur_width();
    if (fw_reg < 3) return 3;
    if (fw_reg > MAXW) return MAXW;
    return fw_reg;
  endfunction

  function automatic int unsigned cur_height();
    return (fh_reg < 3) ? 3 : fh_reg;
  endfunction

  function automatic int window_slope();
    longint ew, ns;
    longint unsigned se, sn, n;
    for (int i = 0; i < 9; i++)
      if (win[i] == nodata_reg) return 0;
    ew = (win[0] + 2 * win[3] + win[6]) - (win[2] + 2 * win[5] + win[8]);
    ns = (win[0] + 2 * win[1] + win[2]) - (win[6] + 2 * win[7] + win[8]);
    se = (ew < 0 ? -ew : ew) * ew_gain;
    sn = (ns < 0 ? -ns : ns) * ns_gain;
    if (se >= (64'd256 << 16) || sn >= (64'd256 << 16)) return 255;
    n = (floor_root((se * se + sn * sn) << 2) + (64'd1 << 16)) >> 17;
    return (n > 255) ? 255 : int'(n);
  endfunction

  function automatic void clear_position();
    col_cnt = 0;
    row_cnt = 0;
    out_cnt = 0;
  endfunction

  function automatic void predict_slope(input logic [15:0] elev, input bit flush_req);
    int unsigned w, h, c, pr, pc, idx;
    bit          drained, fl;
    int          val;
    slope_res_t  r;
    w = cur_width();
    h = cur_height();
    drained = (row_cnt >= h);
    fl = flush_req || drained;
    val = 0;
    if (fl) begin
      if (!drained) return;
    end else begin
      c = col_cnt;
      idx = row_cnt * w + c;
      win[0] = win[1]; win[1] = win[2]; win[2] = upper_row[c];
      win[3] = win[4]; win[4] = win[5]; win[5] = middle_row[c];
      win[6] = win[7]; win[7] = win[8]; win[8] = $signed(elev);
      upper_row[c] = middle_row[c];
      middle_row[c] = $signed(elev);
      col_cnt = c + 1;
      if (col_cnt >= w) begin
        col_cnt = 0;
        row_cnt++;
      end
      if (idx < w + 1) return;
    end
    pr = out_cnt / w;
    pc = out_cnt % w;
    if (!fl && pr != 0 && pr + 1 < h && pc != 0 && pc + 1 < w) val = window_slope();
    r.slope = val[7:0];
    r.eof = (out_cnt + 1 >= w * h);
    if (r.eof) clear_position();
    else out_cnt++;
    pending_slopes.push_back(r);
  endfunction

  // accept side: predict on every input transfer
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) predict_slope(in_tdata, in_tuser[0]);
  end

  // result checker
  always @(posedge clk) begin
    slope_res_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_slopes.size() == 0) begin
        errors++;
        $display("%0t: unexpected result slope=%0d last=%0b", $time, out_tdata, out_tlast);
      end else begin
        exp_r = pending_slopes.pop_front();
        if (exp_r.eof) frames_done++;
        if (out_tdata !== exp_r.slope) begin
          errors++;
          $display("%0t: slope expected %0d actual %0d", $time, exp_r.slope, out_tdata);
        end
        if (out_tlast !== exp_r.eof) begin
          errors++;
          $display("%0t: tlast expected %0b actual %0b", $time, exp_r.eof, out_tlast);
        end
      end
    end
  end

  // receiver stall pattern: four modes in turn, from always ready to mostly stalled
  int unsigned rx_cycle = 0;
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    case ((rx_cycle >> 8) % 4)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 9) < 7);
      2: out_tready <= (rx_cycle % 5) != 0;
      default: out_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(input logic [15:0] elev, input bit fl);
    in_tvalid <= 1'b1;
    in_tdata  <= elev;
    in_tuser  <= fl;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 12);
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_slopes.size() != 0) @(posedge clk);
    repeat (IDLE_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_FRAME_WIDTH:  begin fw_reg = val[12:0]; clear_position(); end
      REG_FRAME_HEIGHT: begin fh_reg = val[15:0]; clear_position(); end
      REG_NODATA:       nodata_reg = $signed(val[15:0]);
      REG_EW_GAIN:      ew_gain = val;
      REG_NS_GAIN:      ns_gain = val;
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // elevation for a given pattern: 0 gentle terrain, 1 full range, 2 with holes
  function automatic logic [15:0] pick_elev(input int kind, input int base);
    int v;
    case (kind)
      0: v = base + $signed($urandom_range(0, 40)) - 20;
      1: v = $signed(16'($urandom));
      default: v = ($urandom_range(0, 7) == 0) ? nodata_reg
                   : base + $signed($urandom_range(0, 16)) - 8;
    endcase
    return v[15:0];
  endfunction

  // one frame of samples with optional in-frame flushes, then the tail
  task automatic run_frame(input int kind, input bit with_flush);
    int unsigned w, h;
    int base;
    w = cur_width();
    h = cur_height();
    base = $signed($urandom_range(0, 60000)) - 30000;
    for (int i = 0; i < w * h; i++) begin
      if (with_flush && $urandom_range(0, 9) == 0) send_item(16'($urandom), 1'b1);
      send_item(pick_elev(kind, base), 1'b0);
    end
    for (int i = 0; i <= w; i++) send_item(16'($urandom), $urandom_range(0, 2) != 0);
  endtask

  task automatic test_directed();
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(3));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(3));
    write_reg(REG_NODATA, CFG_DATA_W'(0));
    write_reg(REG_EW_GAIN, 24'hFFFFFF);
    write_reg(REG_NS_GAIN, 24'h000001);
    send_item(16'h8000, 1'b0); send_item(16'h7FFF, 1'b0); send_item(16'h8000, 1'b1);
    send_item(16'h7FFF, 1'b0); send_item(16'h0001, 1'b0); send_item(16'h8000, 1'b0);
    send_item(16'h7FFF, 1'b0); send_item(16'h8000, 1'b0); send_item(16'h7FFF, 1'b0);
    send_item(16'h0000, 1'b0); send_item(16'hFFFF, 1'b1);
    send_item(16'h1234, 1'b1); send_item(16'h5555, 1'b0); send_item(16'hAAAA, 1'b1);
    wait_idle();
    write_reg(REG_EW_GAIN, CFG_DATA_W'(0));
    write_reg(REG_NS_GAIN, CFG_DATA_W'(0));
    write_reg(REG_NODATA, CFG_DATA_W'(16'h8000));
    run_frame(1, 1'b0);
    wait_idle();
    write_reg(REG_NODATA, CFG_DATA_W'(100));
    write_reg(REG_EW_GAIN, GAIN_RESET);
    write_reg(REG_NS_GAIN, GAIN_RESET);
    for (int i = 0; i < 9; i++) send_item((i == 7) ? 16'd100 : 16'(i * 3), 1'b0);
    for (int i = 0; i < 4; i++) send_item(16'd0, 1'b1);
    wait_idle();
  endtask

  task automatic test_geometry();
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(0));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(0));
    run_frame(0, 1'b1);
    wait_idle();
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(4));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(16'hFFFF));
    for (int i = 0; i < 20; i++) send_item(16'($urandom_range(0, 30)), 1'b0);
    wait_idle();
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(13'h1FFF));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(3));
    for (int i = 0; i < 40; i++) send_item(16'($urandom_range(0, 30)), 1'b0);
    wait_idle();
  endtask

  task automatic test_random();
    int n;
    n = 0;
    while (items_sent < ITEM_GOAL) begin
      write_reg(REG_FRAME_WIDTH, ($urandom_range(0, 5) == 0)
                                 ? CFG_DATA_W'($urandom_range(11, 40))
                                 : CFG_DATA_W'($urandom_range(3, 10)));
      write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'($urandom_range(3, 8)));
      case ($urandom_range(0, 2))
        0: write_reg(REG_EW_GAIN, GAIN_RESET);
        1: write_reg(REG_EW_GAIN, CFG_DATA_W'($urandom_range(0, 24'h0FFFFF)));
        default: write_reg(REG_EW_GAIN, 24'($urandom));
      endcase
      write_reg(REG_NS_GAIN, ($urandom_range(0, 1) != 0) ? GAIN_RESET : 24'($urandom));
      write_reg(REG_NODATA, CFG_DATA_W'(16'($urandom)));
      repeat ($urandom_range(1, 3))
        run_frame(int'($urandom_range(0, 2)), $urandom_range(0, 1) != 0);
      n++;
      if (n % 5 == 0) wait_idle();
      else begin
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_slopes.size() != 0) @(posedge clk);
        repeat (IDLE_WAIT) @(posedge clk);
      end
    end
  endtask

  initial begin
    fw_reg = FW_RESET;
    fh_reg = FH_RESET;
    nodata_reg = -32768;
    ew_gain = GAIN_RESET;
    ns_gain = GAIN_RESET;
    clear_position();
    for (int i = 0; i < 9; i++) win[i] = 0;
    for (int i = 0; i < MAXW; i++) begin
      upper_row[i] = 0;
      middle_row[i] = 0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_geometry();
    test_random();
    wait_idle();
    $display("Covered %0d input transfers, %0d results, %0d complete frames.",
             items_sent, results_seen, frames_done);
    $display("Included clamped and extreme geometry, gains, no-data and tail flushes.");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
